/* src/hs_pkg.sv */
// Shared types, constants and round functions for the HMAC-SHA256 engine.
// Used by hs_ctrl, hs_datapath and hmac_sha256_engine_core.
package hs_pkg;

    localparam logic [3:0]  CFG_LAST  = 4'd7;
    localparam logic [7:0]  IPAD      = 8'h36;
    localparam logic [7:0]  OPAD      = 8'h5c;
    localparam logic [7:0]  PAD_MARK  = 8'h80;
    localparam logic [63:0] KEY_BITS  = 64'd512;
    localparam logic [31:0] OUTER_LEN = 32'd768;

    localparam logic [31:0] IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       start;
        logic       ld_key;
        logic       opad;
        logic       ld_pad;
        logic       ld_zero;
        logic       ld_len;
        logic       ld_dig;
        logic       save;
        logic       init;
        logic       key_done;
        logic       wr_byte;
        logic [7:0] byte_data;
        logic [1:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic busy;
        logic full;
        logic pad_hi;
    } t_sts;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sm_s0(input logic [31:0] x);
        sm_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sm_s1(input logic [31:0] x);
        sm_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* src/hs_datapath.sv */
// SHA-256 datapath: key registers, block window, round unit, chain value.
// Depends on hs_pkg; driven by hs_ctrl through hs_pkg::t_cmd.
module hs_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hs_pkg::t_cmd    i_cmd,
    output hs_pkg::t_sts    o_sts,
    input  logic            i_cfg_we,
    input  logic [3:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_wdata,
    output logic [63:0]     o_digest_word
);

    logic [63:0] r_key   [0:7];
    logic [31:0] r_chain [0:7];
    logic [31:0] r_inner [0:7];
    logic [31:0] r_w     [0:15];
    logic [31:0] n_w     [0:15];
    logic [31:0] r_v     [0:7];
    logic [31:0] n_v     [0:7];
    logic [5:0]  r_rnd;
    logic        r_run;
    logic        r_fin;
    logic [5:0]  r_cnt;
    logic [63:0] r_total;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;
    logic [7:0]  pad_byte;
    logic [4:0]  bsh;

    assign pad_byte = i_cmd.opad ? hs_pkg::OPAD : hs_pkg::IPAD;
    assign bsh      = {~r_cnt[1:0], 3'b000};

    always_comb begin
        t1 = r_v[7] + hs_pkg::big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + hs_pkg::ROUND_K[r_rnd] + r_w[0];
        t2 = hs_pkg::big_s0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        n_v[0] = t1 + t2;
        n_v[1] = r_v[0];
        n_v[2] = r_v[1];
        n_v[3] = r_v[2];
        n_v[4] = r_v[3] + t1;
        n_v[5] = r_v[4];
        n_v[6] = r_v[5];
        n_v[7] = r_v[6];
        w_new = hs_pkg::sm_s1(r_w[14]) + r_w[9] + hs_pkg::sm_s0(r_w[1]) + r_w[0];
    end

    always_comb begin
        n_w = r_w;
        if (r_run) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = r_w[i + 1];
            end
            n_w[15] = w_new;
        end
        if (i_cmd.ld_key) begin
            for (int i = 0; i < 16; i++) begin
                n_w[i] = (i % 2 == 1) ? r_key[i / 2][31:0] : r_key[i / 2][63:32];
                n_w[i] = n_w[i] ^ {4{pad_byte}};
            end
        end
        if (i_cmd.ld_pad) begin
            for (int j = 0; j < 64; j++) begin
                if (6'(j) == r_cnt) begin
                    n_w[j / 4][(3 - (j % 4)) * 8 +: 8] = hs_pkg::PAD_MARK;
                end else if (6'(j) > r_cnt) begin
                    n_w[j / 4][(3 - (j % 4)) * 8 +: 8] = 8'h00;
                end
            end
        end
        if (i_cmd.ld_zero) begin
            for (int i = 0; i < 16; i++) begin
                n_w[i] = 32'h0;
            end
        end
        if (i_cmd.ld_len) begin
            n_w[14] = r_total[63:32];
            n_w[15] = r_total[31:0];
        end
        if (i_cmd.ld_dig) begin
            for (int i = 0; i < 8; i++) begin
                n_w[i] = r_inner[i];
            end
            n_w[8] = {hs_pkg::PAD_MARK, 24'h0};
            for (int i = 9; i < 15; i++) begin
                n_w[i] = 32'h0;
            end
            n_w[15] = hs_pkg::OUTER_LEN;
        end
        if (i_cmd.wr_byte) begin
            n_w[r_cnt[5:2]][bsh +: 8] = i_cmd.byte_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        if (i_cmd.start) begin
            r_v <= r_chain;
        end else if (r_run) begin
            r_v <= n_v;
        end
        if (i_cmd.save) begin
            r_inner <= r_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_key[i]   <= 64'h0;
                r_chain[i] <= hs_pkg::IV[i];
            end
            r_rnd   <= 6'd0;
            r_run   <= 1'b0;
            r_fin   <= 1'b0;
            r_cnt   <= 6'd0;
            r_total <= 64'd0;
        end else begin
            if (i_cfg_we && i_cfg_index <= hs_pkg::CFG_LAST) begin
                r_key[i_cfg_index[2:0]] <= i_cfg_wdata;
            end
            r_fin <= 1'b0;
            if (i_cmd.start) begin
                r_run <= 1'b1;
                r_rnd <= 6'd0;
            end else if (r_run) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end
            if (r_fin) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_v[i];
                end
            end
            if (i_cmd.init) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= hs_pkg::IV[i];
                end
            end
            if (i_cmd.key_done) begin
                r_cnt   <= 6'd0;
                r_total <= hs_pkg::KEY_BITS;
            end else if (i_cmd.wr_byte) begin
                r_cnt   <= r_cnt + 6'd1;
                r_total <= r_total + 64'd8;
            end
        end
    end

    assign o_sts.done   = r_fin;
    assign o_sts.busy   = r_run | r_fin;
    assign o_sts.full   = (r_cnt == 6'd63);
    assign o_sts.pad_hi = (r_cnt[5:3] == 3'b111);

    assign o_digest_word = {r_chain[{i_cmd.out_idx, 1'b0}], r_chain[{i_cmd.out_idx, 1'b1}]};

endmodule

/* src/hs_ctrl.sv */
// Controller for the HMAC-SHA256 engine: item handshake, block sequencing, output.
// Depends on hs_pkg; commands hs_datapath.
module hs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_byte_valid,
    input  logic            i_last,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_word_index,
    output logic            o_final_word,
    output hs_pkg::t_cmd    o_cmd,
    input  hs_pkg::t_sts    i_sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_KRUN  = 4'd1;
    localparam logic [3:0] S_BYTE  = 4'd2;
    localparam logic [3:0] S_MRUN  = 4'd3;
    localparam logic [3:0] S_PAD   = 4'd4;
    localparam logic [3:0] S_P1RUN = 4'd5;
    localparam logic [3:0] S_ZL    = 4'd6;
    localparam logic [3:0] S_IRUN  = 4'd7;
    localparam logic [3:0] S_SAVE  = 4'd8;
    localparam logic [3:0] S_OKEY  = 4'd9;
    localparam logic [3:0] S_ORUN  = 4'd10;
    localparam logic [3:0] S_ODIG  = 4'd11;
    localparam logic [3:0] S_DRUN  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_loaded;
    logic       n_loaded;
    logic [1:0] r_oidx;
    logic [1:0] n_oidx;
    logic [7:0] r_byte;
    logic       r_bv;
    logic       r_last;
    logic       accept;

    assign o_ready      = (r_state == S_IDLE);
    assign accept       = i_valid && o_ready;
    assign o_valid      = (r_state == S_OUT);
    assign o_word_index = r_oidx;
    assign o_final_word = (r_oidx == 2'd3);

    always_comb begin
        n_state = r_state;
        n_loaded = r_loaded;
        n_oidx = r_oidx;
        o_cmd = '0;
        o_cmd.byte_data = r_byte;
        o_cmd.out_idx = r_oidx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!r_loaded) begin
                        o_cmd.ld_key = 1'b1;
                        o_cmd.start = 1'b1;
                        n_state = S_KRUN;
                    end else begin
                        n_state = S_BYTE;
                    end
                end
            end
            S_KRUN: begin
                if (i_sts.done) begin
                    o_cmd.key_done = 1'b1;
                    n_loaded = 1'b1;
                    n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                o_cmd.wr_byte = r_bv;
                if (r_bv && i_sts.full) begin
                    o_cmd.start = 1'b1;
                    n_state = S_MRUN;
                end else begin
                    n_state = r_last ? S_PAD : S_IDLE;
                end
            end
            S_MRUN: begin
                if (i_sts.done) begin
                    n_state = r_last ? S_PAD : S_IDLE;
                end
            end
            S_PAD: begin
                o_cmd.ld_pad = 1'b1;
                o_cmd.start = 1'b1;
                if (i_sts.pad_hi) begin
                    n_state = S_P1RUN;
                end else begin
                    o_cmd.ld_len = 1'b1;
                    n_state = S_IRUN;
                end
            end
            S_P1RUN: begin
                if (i_sts.done) begin
                    n_state = S_ZL;
                end
            end
            S_ZL: begin
                o_cmd.ld_zero = 1'b1;
                o_cmd.ld_len = 1'b1;
                o_cmd.start = 1'b1;
                n_state = S_IRUN;
            end
            S_IRUN: begin
                if (i_sts.done) begin
                    n_state = S_SAVE;
                end
            end
            S_SAVE: begin
                o_cmd.save = 1'b1;
                o_cmd.init = 1'b1;
                n_state = S_OKEY;
            end
            S_OKEY: begin
                o_cmd.ld_key = 1'b1;
                o_cmd.opad = 1'b1;
                o_cmd.start = 1'b1;
                n_state = S_ORUN;
            end
            S_ORUN: begin
                if (i_sts.done) begin
                    n_state = S_ODIG;
                end
            end
            S_ODIG: begin
                o_cmd.ld_dig = 1'b1;
                o_cmd.start = 1'b1;
                n_state = S_DRUN;
            end
            S_DRUN: begin
                if (i_sts.done) begin
                    n_oidx = 2'd0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_oidx = r_oidx + 2'd1;
                    if (r_oidx == 2'd3) begin
                        o_cmd.init = 1'b1;
                        n_loaded = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_loaded <= 1'b0;
            r_oidx   <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_oidx   <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
            r_bv   <= i_byte_valid;
            r_last <= i_last;
        end
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> !i_sts.busy)
        else $error("compression started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !i_sts.busy)
        else $error("item taken while datapath busy");
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_final_word) |=> (o_ready && !o_valid))
        else $error("block not idle after last digest word");
`endif

endmodule

/* src/hmac_sha256_engine_core.sv */
// HMAC-SHA256 engine top level: the controller and the SHA-256 datapath.
// Depends on hs_pkg, hs_ctrl and hs_datapath.
//
// Usage: load the 64-byte key through i_cfg_we/i_cfg_index/i_cfg_wdata
// (words 0..7, big-endian, zero padded) while the block is idle. Send one
// item per message byte on i_valid/o_ready; i_byte_valid marks a byte and
// i_last ends the message (an item may carry only i_last).
// The block takes no new item until it is back in idle; the first item of a
// message adds a compression of the key block, and every 64th byte adds a block
// compression. The round unit does one SHA-256 round per cycle, so each
// block compression is 64 rounds followed by a chain add.
// After the last item the block runs 3 or 4 more compressions,
// then presents the MAC as four 64-bit words on
// o_valid/i_ready, index 0 first, o_final_word on the fourth.
// o_ready stays low until all four words are taken; a stalled receiver
// holds the word and index steady. Synchronous reset clears the key,
// restores the initial hash and drops any message in progress.
module hmac_sha256_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_final_word,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata
);

    hs_pkg::t_cmd cmd;
    hs_pkg::t_sts sts;

    hs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word_index (o_word_index),
        .o_final_word (o_final_word),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    hs_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_digest_word (o_digest_word)
    );

endmodule
